// ===== hw/rtl/spatial_stereo_gain_core_assert.svh =====
// Assertion macros for the checker of the spatial stereo gain core.
`ifndef SPATIAL_STEREO_GAIN_CORE_ASSERT_SVH
`define SPATIAL_STEREO_GAIN_CORE_ASSERT_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define SSG_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds across reset.
`define SSG_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/ssg_pkg.sv =====
// ---------------------------------------------------------------------------
// Spatial stereo gain package
// Widths, register codes and the pipeline word types used across the design.
// ---------------------------------------------------------------------------
package ssg_pkg;

   localparam int unsigned WORLD_EXTENT_DEF = 4096;

   localparam int POS_W      = 20;
   localparam int GAIN_W     = 16;
   localparam int RIGHT_W    = 16;
   localparam int OUT_GAIN_W = 16;
   localparam int DIST_W     = 20;

   localparam int DELTA_W = 21;
   localparam int SQ_W    = 40;
   localparam int DSQ_W   = 42;
   localparam int ROOT_W  = 21;
   localparam int PROD_W  = DELTA_W + RIGHT_W;
   localparam int DOT_W   = 39;
   localparam int PREM_W  = 38;
   localparam int REF2_W  = 40;
   localparam int ADEN_W  = 43;
   localparam int AREM_W  = 56;
   localparam int QUO_W   = 18;
   localparam int ATT_W   = 17;
   localparam int PAN_W   = 19;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [OUT_GAIN_W-1:0] GAIN_ONE = 16'h8000;
   localparam logic [15:0]           HALF_ONE = 16'h4000;

   typedef enum logic {
      CSR_REF_DISTANCE = 1'b0,
      CSR_MAX_DISTANCE = 1'b1
   } csr_index_type;

   // Word that walks down the square root chain.
   typedef struct packed {
      logic [DSQ_W-1:0]        rem;
      logic [ROOT_W-1:0]       root;
      logic signed [DOT_W-1:0] dot;
      logic [DSQ_W-1:0]        dsq;
      logic [GAIN_W-1:0]       gain;
      logic                    far;
      logic                    zero;
   } root_word_type;

   // Word that walks down the divider chain: pan lane and attenuation lane.
   typedef struct packed {
      logic [PREM_W-1:0] prem;
      logic [ROOT_W-1:0] pden;
      logic [QUO_W-1:0]  pq;
      logic              pneg;
      logic [AREM_W-1:0] arem;
      logic [ADEN_W-1:0] aden;
      logic [QUO_W-1:0]  aq;
      logic [GAIN_W-1:0] gain;
      logic              far;
      logic              zero;
   } div_word_type;

endpackage

// ===== hw/rtl/ssg_if.sv =====
// ---------------------------------------------------------------------------
// Spatial stereo gain channels
// Valid/ready channels for the source transaction and the gain result.
// ---------------------------------------------------------------------------
interface ssg_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [ssg_pkg::POS_W-1:0]             source_x;
   logic [ssg_pkg::POS_W-1:0]             source_y;
   logic [ssg_pkg::POS_W-1:0]             source_z;
   logic [ssg_pkg::GAIN_W-1:0]            source_gain;
   logic [ssg_pkg::POS_W-1:0]             listener_x;
   logic [ssg_pkg::POS_W-1:0]             listener_y;
   logic [ssg_pkg::POS_W-1:0]             listener_z;
   logic signed [ssg_pkg::RIGHT_W-1:0]    right_x;
   logic signed [ssg_pkg::RIGHT_W-1:0]    right_y;
   logic signed [ssg_pkg::RIGHT_W-1:0]    right_z;

   modport source (output valid, source_x, source_y, source_z, source_gain,
                   listener_x, listener_y, listener_z, right_x, right_y, right_z,
                   input ready);
   modport sink (input valid, source_x, source_y, source_z, source_gain,
                 listener_x, listener_y, listener_z, right_x, right_y, right_z,
                 output ready);
endinterface

interface ssg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ssg_pkg::DIST_W-1:0]        distance;
   logic [ssg_pkg::OUT_GAIN_W-1:0]    gain_left;
   logic [ssg_pkg::OUT_GAIN_W-1:0]    gain_right;

   modport source (output valid, distance, gain_left, gain_right, input ready);
   modport sink (input valid, distance, gain_left, gain_right, output ready);
endinterface

// ===== hw/rtl/ssg_root_cell.sv =====
// ---------------------------------------------------------------------------
// Square root cell
// Decides one bit of the integer square root and hands the word onward.
// ---------------------------------------------------------------------------
module ssg_root_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ssg_pkg::root_word_type in_word,
   input  logic                   down_en,
   output logic                   up_en,
   output logic                   out_valid,
   output ssg_pkg::root_word_type out_word
);
   localparam int T_W = ssg_pkg::DSQ_W + 2;

   logic [T_W-1:0]         trial;
   logic                   take;
   logic                   valid_ff;
   ssg_pkg::root_word_type word_ff;
   ssg_pkg::root_word_type word_in;

   // Trial subtrahend (2*root + 2^k) * 2^k for the bit under test.
   assign trial = (T_W'(in_word.root) << (BIT_POS + 1)) + (T_W'(1) << (2 * BIT_POS));
   assign take  = T_W'(in_word.rem) >= trial;

   always_comb begin
      word_in = in_word;
      if (take) begin
         word_in.rem              = ssg_pkg::DSQ_W'(T_W'(in_word.rem) - trial);
         word_in.root[BIT_POS]    = 1'b1;
      end
   end

   assign up_en = !valid_ff || down_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule

// ===== hw/rtl/ssg_div_cell.sv =====
// ---------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for the pan and the attenuation division.
// ---------------------------------------------------------------------------
module ssg_div_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ssg_pkg::div_word_type in_word,
   input  logic                  down_en,
   output logic                  up_en,
   output logic                  out_valid,
   output ssg_pkg::div_word_type out_word
);
   localparam int PT_W = ssg_pkg::ROOT_W + ssg_pkg::QUO_W;
   localparam int AT_W = ssg_pkg::ADEN_W + ssg_pkg::QUO_W;

   logic [PT_W-1:0]       p_shift;
   logic [AT_W-1:0]       a_shift;
   logic                  p_take;
   logic                  a_take;
   logic                  valid_ff;
   ssg_pkg::div_word_type word_ff;
   ssg_pkg::div_word_type word_in;

   assign p_shift = PT_W'(in_word.pden) << BIT_POS;
   assign a_shift = AT_W'(in_word.aden) << BIT_POS;
   assign p_take  = PT_W'(in_word.prem) >= p_shift;
   assign a_take  = AT_W'(in_word.arem) >= a_shift;

   always_comb begin
      word_in = in_word;
      if (p_take) begin
         word_in.prem        = ssg_pkg::PREM_W'(PT_W'(in_word.prem) - p_shift);
         word_in.pq[BIT_POS] = 1'b1;
      end
      if (a_take) begin
         word_in.arem        = ssg_pkg::AREM_W'(AT_W'(in_word.arem) - a_shift);
         word_in.aq[BIT_POS] = 1'b1;
      end
   end

   assign up_en = !valid_ff || down_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
endmodule

// ===== hw/rtl/spatial_stereo_gain_core.sv =====
// A source passes s1 to s5, the root and divider chains, g1 and the output.
// Throughput: one source per cycle while the output is not stalled; every
// stage is a register; the square root chain has 21 cells, the divider 18.
// A stalled output only holds the stages that are full; bubbles still close up.
// Reset (synchronous, active high) empties the pipeline and restores the
// roll-off distance to 1.0 and the cutoff distance to its maximum.
// ---------------------------------------------------------------------------
// Spatial stereo gain core
// Wrapped distance, inverse square roll-off and linear pan for one source.
// ---------------------------------------------------------------------------
module spatial_stereo_gain_core #(
   parameter int unsigned WORLD_EXTENT = ssg_pkg::WORLD_EXTENT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ssg_req_if.sink                           req_bus,
   ssg_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ssg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ssg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ssg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   localparam int unsigned EXT     = WORLD_EXTENT * 256;
   localparam int          EXT_LOG = $clog2(EXT);
   localparam int          U_W     = (EXT_LOG + 2 > ssg_pkg::DELTA_W + 1) ?
                                     EXT_LOG + 2 : ssg_pkg::DELTA_W + 1;
   localparam int unsigned BIAS_K  = ((1 << ssg_pkg::POS_W) + EXT - 1) / EXT;
   localparam longint unsigned BIAS   = longint'(BIAS_K) * longint'(EXT);
   localparam longint unsigned RECIP  = (64'd1 << 32) / EXT;
   localparam int          RCP_W   = $clog2(RECIP + 1);
   localparam int          P_W     = U_W + RCP_W;
   localparam int          Q_W     = P_W - 32;
   localparam int          E_W     = U_W + Q_W;
   localparam int          H_W     = ssg_pkg::PAN_W + 1;
   localparam int          GA_W    = ssg_pkg::GAIN_W + ssg_pkg::ATT_W;
   localparam int          V_W     = GA_W + H_W - 1;
   localparam int          VS_W    = V_W - 30;

   localparam logic [U_W-1:0]   EXT_V   = U_W'(EXT);
   localparam logic [U_W-1:0]   HALF_V  = U_W'(EXT / 2);
   localparam logic [U_W-1:0]   BIAS_V  = U_W'(BIAS);
   localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);

   // Configuration registers.
   logic [ssg_pkg::POS_W-1:0]  ref_distance_ff;
   logic [ssg_pkg::POS_W-1:0]  max_distance_ff;
   logic [ssg_pkg::REF2_W-1:0] ref2_ff;
   logic [ssg_pkg::REF2_W-1:0] max2_ff;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_distance_ff <= ssg_pkg::POS_W'(256);
         max_distance_ff <= '1;
      end else if (csr_write) begin
         unique case (ssg_pkg::csr_index_type'(csr_paddr[2]))
            ssg_pkg::CSR_REF_DISTANCE: ref_distance_ff <= csr_pwdata[ssg_pkg::POS_W-1:0];
            ssg_pkg::CSR_MAX_DISTANCE: max_distance_ff <= csr_pwdata[ssg_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ref2_ff <= ssg_pkg::REF2_W'(ref_distance_ff) * ssg_pkg::REF2_W'(ref_distance_ff);
      max2_ff <= ssg_pkg::REF2_W'(max_distance_ff) * ssg_pkg::REF2_W'(max_distance_ff);
   end

   always_comb begin
      unique case (ssg_pkg::csr_index_type'(csr_paddr[2]))
         ssg_pkg::CSR_REF_DISTANCE: csr_prdata = ssg_pkg::CSR_DATA_W'(ref_distance_ff);
         ssg_pkg::CSR_MAX_DISTANCE: csr_prdata = ssg_pkg::CSR_DATA_W'(max_distance_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Stage enables ripple back from the output register.
   logic en_s1, en_s2, en_s3, en_s4, en_s5, en_g1, en_out;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, g1_v_ff, rsp_v_ff;
   logic root_en [ssg_pkg::ROOT_W+1];
   logic div_en  [ssg_pkg::QUO_W+1];
   logic div_v   [ssg_pkg::QUO_W+1];

   assign en_out = !rsp_v_ff || rsp_bus.ready;
   assign en_g1  = !g1_v_ff || en_out;
   assign en_s5  = !s5_v_ff || root_en[0];
   assign en_s4  = !s4_v_ff || en_s5;
   assign en_s3  = !s3_v_ff || en_s4;
   assign en_s2  = !s2_v_ff || en_s3;
   assign en_s1  = !s1_v_ff || en_s2;
   assign req_bus.ready = en_s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         g1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (en_s1)  s1_v_ff  <= req_bus.valid;
         if (en_s2)  s2_v_ff  <= s1_v_ff;
         if (en_s3)  s3_v_ff  <= s2_v_ff;
         if (en_s4)  s4_v_ff  <= s3_v_ff;
         if (en_s5)  s5_v_ff  <= s4_v_ff;
         if (en_g1)  g1_v_ff  <= div_v[ssg_pkg::QUO_W];
         if (en_out) rsp_v_ff <= g1_v_ff;
      end
   end

   // Front end: wrap the three axes, then square and project.
   logic [ssg_pkg::POS_W-1:0]          src_pos [3];
   logic [ssg_pkg::POS_W-1:0]          lis_pos [3];
   logic signed [ssg_pkg::RIGHT_W-1:0] right_in [3];

   assign src_pos[0]  = req_bus.source_x;
   assign src_pos[1]  = req_bus.source_y;
   assign src_pos[2]  = req_bus.source_z;
   assign lis_pos[0]  = req_bus.listener_x;
   assign lis_pos[1]  = req_bus.listener_y;
   assign lis_pos[2]  = req_bus.listener_z;
   assign right_in[0] = req_bus.right_x;
   assign right_in[1] = req_bus.right_y;
   assign right_in[2] = req_bus.right_z;

   logic [U_W-1:0]                      u_ff     [3];
   logic [Q_W-1:0]                      q_ff     [3];
   logic [U_W-1:0]                      r0_ff    [3];
   logic signed [ssg_pkg::DELTA_W-1:0]  d_ff     [3];
   logic [ssg_pkg::SQ_W-1:0]            sq_ff    [3];
   logic signed [ssg_pkg::PROD_W-1:0]   pr_ff    [3];
   logic signed [ssg_pkg::RIGHT_W-1:0]  right1_ff [3];
   logic signed [ssg_pkg::RIGHT_W-1:0]  right2_ff [3];
   logic signed [ssg_pkg::RIGHT_W-1:0]  right3_ff [3];
   logic [ssg_pkg::GAIN_W-1:0]          gain1_ff, gain2_ff, gain3_ff, gain4_ff, gain5_ff;
   logic [ssg_pkg::DSQ_W-1:0]           dsq_ff;
   logic signed [ssg_pkg::DOT_W-1:0]    dot_ff;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [U_W-1:0]                     u_in;
      logic [P_W-1:0]                     prod;
      logic [E_W-1:0]                     qe;
      logic [U_W-1:0]                     r1;
      logic signed [ssg_pkg::DELTA_W-1:0] d_in;
      logic signed [2*ssg_pkg::DELTA_W-1:0] sq_full;
      logic signed [ssg_pkg::PROD_W-1:0]  pr_full;

      // Biased difference is never negative and keeps its residue.
      assign u_in = U_W'(src_pos[a]) + BIAS_V - U_W'(lis_pos[a]);
      // The reciprocal estimate of the quotient is low by at most one.
      assign prod = P_W'(u_in) * P_W'(RECIP_V);
      assign qe   = E_W'(q_ff[a]) * E_W'(EXT_V);
      assign r1   = (r0_ff[a] >= EXT_V) ? r0_ff[a] - EXT_V : r0_ff[a];
      assign d_in = (r1 >= HALF_V) ? ssg_pkg::DELTA_W'(r1 - EXT_V) : ssg_pkg::DELTA_W'(r1);
      assign sq_full = d_ff[a] * d_ff[a];
      assign pr_full = d_ff[a] * right3_ff[a];

      always_ff @(posedge clock) begin
         if (en_s1) begin
            u_ff[a]      <= u_in;
            q_ff[a]      <= prod[P_W-1:32];
            right1_ff[a] <= right_in[a];
         end
         if (en_s2) begin
            r0_ff[a]     <= u_ff[a] - qe[U_W-1:0];
            right2_ff[a] <= right1_ff[a];
         end
         if (en_s3) begin
            d_ff[a]      <= d_in;
            right3_ff[a] <= right2_ff[a];
         end
         if (en_s4) begin
            sq_ff[a] <= sq_full[ssg_pkg::SQ_W-1:0];
            pr_ff[a] <= pr_full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) gain1_ff <= req_bus.source_gain;
      if (en_s2) gain2_ff <= gain1_ff;
      if (en_s3) gain3_ff <= gain2_ff;
      if (en_s4) gain4_ff <= gain3_ff;
      if (en_s5) begin
         gain5_ff <= gain4_ff;
         dsq_ff   <= ssg_pkg::DSQ_W'(sq_ff[0]) + ssg_pkg::DSQ_W'(sq_ff[1])
                     + ssg_pkg::DSQ_W'(sq_ff[2]);
         dot_ff   <= ssg_pkg::DOT_W'(pr_ff[0]) + ssg_pkg::DOT_W'(pr_ff[1])
                     + ssg_pkg::DOT_W'(pr_ff[2]);
      end
   end

   // Square root chain, most significant root bit first.
   ssg_pkg::root_word_type root_w [ssg_pkg::ROOT_W+1];
   logic                   root_v [ssg_pkg::ROOT_W+1];

   always_comb begin
      root_w[0]      = '0;
      root_w[0].rem  = dsq_ff;
      root_w[0].dsq  = dsq_ff;
      root_w[0].dot  = dot_ff;
      root_w[0].gain = gain5_ff;
      root_w[0].far  = dsq_ff > ssg_pkg::DSQ_W'(max2_ff);
      root_w[0].zero = dsq_ff == '0;
   end
   assign root_v[0] = s5_v_ff;
   assign root_en[ssg_pkg::ROOT_W] = div_en[0];

   for (genvar k = 0; k < ssg_pkg::ROOT_W; k++) begin : g_root
      ssg_root_cell #(
         .BIT_POS (ssg_pkg::ROOT_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (root_v[k]),
         .in_word   (root_w[k]),
         .down_en   (root_en[k+1]),
         .up_en     (root_en[k]),
         .out_valid (root_v[k+1]),
         .out_word  (root_w[k+1])
      );
   end

   // Divider chain: |dot| / root for the pan, ref^2 * 2^16 / (ref^2 + d^2).
   ssg_pkg::div_word_type div_w [ssg_pkg::QUO_W+1];
   ssg_pkg::root_word_type rt;
   logic signed [ssg_pkg::DOT_W-1:0] dot_mag;

   assign rt      = root_w[ssg_pkg::ROOT_W];
   assign dot_mag = rt.dot[ssg_pkg::DOT_W-1] ? -rt.dot : rt.dot;

   always_comb begin
      div_w[0]      = '0;
      div_w[0].prem = dot_mag[ssg_pkg::PREM_W-1:0];
      div_w[0].pneg = rt.dot[ssg_pkg::DOT_W-1];
      div_w[0].pden = rt.root;
      div_w[0].arem = ssg_pkg::AREM_W'(ref2_ff) << 16;
      div_w[0].aden = ssg_pkg::ADEN_W'(ref2_ff) + ssg_pkg::ADEN_W'(rt.dsq);
      div_w[0].gain = rt.gain;
      div_w[0].far  = rt.far;
      div_w[0].zero = rt.zero;
   end
   assign div_v[0] = root_v[ssg_pkg::ROOT_W];
   assign div_en[ssg_pkg::QUO_W] = en_g1;

   for (genvar k = 0; k < ssg_pkg::QUO_W; k++) begin : g_div
      ssg_div_cell #(
         .BIT_POS (ssg_pkg::QUO_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_v[k]),
         .in_word   (div_w[k]),
         .down_en   (div_en[k+1]),
         .up_en     (div_en[k]),
         .out_valid (div_v[k+1]),
         .out_word  (div_w[k+1])
      );
   end

   // Gain stage one: signed pan, half pans and gain times attenuation.
   ssg_pkg::div_word_type            dv;
   logic signed [ssg_pkg::PAN_W-1:0] pan;
   logic signed [H_W-1:0]            hl_ff, hr_ff;
   logic [GA_W-1:0]                  ga_ff;
   logic [ssg_pkg::GAIN_W-1:0]       gain6_ff;
   logic                             far_ff, zero_ff;
   logic [ssg_pkg::DIST_W-1:0]       dist_ff;

   assign dv  = div_w[ssg_pkg::QUO_W];
   assign pan = dv.pneg ? -signed'(ssg_pkg::PAN_W'(dv.pq)) : signed'(ssg_pkg::PAN_W'(dv.pq));

   always_ff @(posedge clock) begin
      if (en_g1) begin
         hl_ff    <= signed'(H_W'(ssg_pkg::HALF_ONE)) - H_W'(pan);
         hr_ff    <= signed'(H_W'(ssg_pkg::HALF_ONE)) + H_W'(pan);
         ga_ff    <= GA_W'(dv.gain) * GA_W'(dv.aq[ssg_pkg::ATT_W-1:0]);
         gain6_ff <= dv.gain;
         far_ff   <= dv.far;
         zero_ff  <= dv.zero;
         // Root of a value below 2^42 fits 21 bits; the top bit means saturate.
         dist_ff  <= dv.pden[ssg_pkg::ROOT_W-1] ? '1 : dv.pden[ssg_pkg::DIST_W-1:0];
      end
   end

   // Gain stage two: per channel product, saturation and special cases.
   function automatic logic [ssg_pkg::OUT_GAIN_W-1:0] chan_gain(
      input logic [GA_W-1:0] ga,
      input logic signed [H_W-1:0] h
   );
      logic [V_W-1:0]  v;
      logic [VS_W-1:0] vs;
      v  = V_W'(ga) * V_W'(h[H_W-2:0]);
      vs = v[V_W-1:30];
      if (h <= 0) begin
         return '0;
      end else if (vs > VS_W'(ssg_pkg::GAIN_ONE)) begin
         return ssg_pkg::GAIN_ONE;
      end else begin
         return vs[ssg_pkg::OUT_GAIN_W-1:0];
      end
   endfunction

   logic [ssg_pkg::OUT_GAIN_W-1:0] gl_in, gr_in, g_half;
   logic [ssg_pkg::OUT_GAIN_W-1:0] gl_ff, gr_ff;
   logic [ssg_pkg::DIST_W-1:0]     dist_out_ff;

   assign g_half = (gain6_ff > ssg_pkg::GAIN_ONE) ? ssg_pkg::GAIN_ONE : gain6_ff;

   always_comb begin
      if (zero_ff) begin
         gl_in = g_half;
         gr_in = g_half;
      end else if (far_ff) begin
         gl_in = '0;
         gr_in = '0;
      end else begin
         gl_in = chan_gain(ga_ff, hl_ff);
         gr_in = chan_gain(ga_ff, hr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         gl_ff       <= gl_in;
         gr_ff       <= gr_in;
         dist_out_ff <= dist_ff;
      end
   end

   assign rsp_bus.valid      = rsp_v_ff;
   assign rsp_bus.distance   = dist_out_ff;
   assign rsp_bus.gain_left  = gl_ff;
   assign rsp_bus.gain_right = gr_ff;
endmodule

// ===== hw/rtl/ssg_checker.sv =====
// ---------------------------------------------------------------------------
// Spatial stereo gain checker
// Port-level checks on the result channel, bound to the core.
// ---------------------------------------------------------------------------
`include "spatial_stereo_gain_core_assert.svh"

module ssg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ssg_pkg::DIST_W-1:0]         distance,
   input logic [ssg_pkg::OUT_GAIN_W-1:0]     gain_left,
   input logic [ssg_pkg::OUT_GAIN_W-1:0]     gain_right
);
   // A stalled transaction keeps its values.
   `SSG_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(gain_left) && $stable(gain_right) && $stable(distance), "result changed while stalled")

   // The pipeline is empty right after reset.
   `SSG_CHECK_ALWAYS(a_rsp_reset, reset |=> !rsp_valid, "result valid after reset")

   // Gains never pass unity.
   `SSG_CHECK(a_gain_range, rsp_valid |-> gain_left <= ssg_pkg::GAIN_ONE && gain_right <= ssg_pkg::GAIN_ONE, "gain above unity")

   // A source on top of the listener is heard equally on both sides.
   `SSG_CHECK(a_zero_center, rsp_valid && distance == '0 |-> gain_left == gain_right, "unbalanced gain at zero distance")
endmodule

bind spatial_stereo_gain_core ssg_checker u_ssg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .distance   (rsp_bus.distance),
   .gain_left  (rsp_bus.gain_left),
   .gain_right (rsp_bus.gain_right)
);

// ===== tb/spatial_stereo_gain_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Spatial stereo gain core testbench
// Sends source transactions with random idling and stalls, predicts the
// wrapped distance and the two channel gains in integer arithmetic, and
// compares every result transaction field by field in arrival order.
// ---------------------------------------------------------------------------
module spatial_stereo_gain_core_tb;

   typedef struct {
      logic [ssg_pkg::POS_W-1:0]          sx, sy, sz;
      logic [ssg_pkg::GAIN_W-1:0]         gain;
      logic [ssg_pkg::POS_W-1:0]          lx, ly, lz;
      logic signed [ssg_pkg::RIGHT_W-1:0] rx, ry, rz;
   } source_rec_type;

   typedef struct {
      logic [ssg_pkg::DIST_W-1:0]     distance;
      logic [ssg_pkg::OUT_GAIN_W-1:0] left;
      logic [ssg_pkg::OUT_GAIN_W-1:0] right;
   } gain_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ssg_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ssg_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ssg_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   ssg_req_if req_if();
   ssg_rsp_if rsp_if();

   spatial_stereo_gain_core dut (
      .clock(clock), .reset(reset), .req_bus(req_if), .rsp_bus(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   gain_rec_type pending_gains[$];
   longint  rolloff_sq_ref = 256;
   longint  cutoff_dist = 1048575;
   int      fail_count = 0;
   bit      idle_on = 1'b1;
   int      hold_cycles = 0;
   int      stall_left = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.source_x = '0; req_if.source_y = '0; req_if.source_z = '0;
      req_if.source_gain = '0;
      req_if.listener_x = '0; req_if.listener_y = '0; req_if.listener_z = '0;
      req_if.right_x = '0; req_if.right_y = '0; req_if.right_z = '0;
      rsp_if.ready = 1'b0;
   end

   // Shortest signed difference on a world of 2^20 LSBs.
   function automatic longint axis_delta(logic [ssg_pkg::POS_W-1:0] s,
                                         logic [ssg_pkg::POS_W-1:0] l);
      longint r;
      r = longint'(s) - longint'(l);
      if (r < 0) r += 64'sd1048576;
      if (r >= 64'sd524288) r -= 64'sd1048576;
      return r;
   endfunction

   function automatic longint floor_root(longint v);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] channel_level(longint g, longint att, longint half);
      longint v;
      if (half <= 0) return 16'd0;
      v = (g * att * half) >>> 30;
      return (v > 32768) ? ssg_pkg::GAIN_ONE : 16'(v);
   endfunction

   function automatic gain_rec_type predict_gains(source_rec_type s);
      gain_rec_type o;
      longint dx, dy, dz, dsq, dq, ref2, att, dot, pan;
      dx = axis_delta(s.sx, s.lx);
      dy = axis_delta(s.sy, s.ly);
      dz = axis_delta(s.sz, s.lz);
      dsq = dx * dx + dy * dy + dz * dz;
      dq = floor_root(dsq);
      o.distance = (dq > 1048575) ? 20'hFFFFF : 20'(dq);
      o.left = '0;
      o.right = '0;
      if (dsq == 0) begin
         o.left = (s.gain > ssg_pkg::GAIN_ONE) ? ssg_pkg::GAIN_ONE : s.gain;
         o.right = o.left;
      end else if (dsq <= cutoff_dist * cutoff_dist) begin
         ref2 = rolloff_sq_ref * rolloff_sq_ref;
         att = (ref2 <<< 16) / (ref2 + dsq);
         dot = dx * longint'(s.rx) + dy * longint'(s.ry) + dz * longint'(s.rz);
         pan = dot / dq;
         o.left = channel_level(longint'(s.gain), att, 16384 - pan);
         o.right = channel_level(longint'(s.gain), att, 16384 + pan);
      end
      return o;
   endfunction

   // Prediction on accepted sources and comparison of accepted results.
   always @(posedge clock) begin
      gain_rec_type want;
      source_rec_type s;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_gains.size() == 0) begin
               $error("result transaction with no expectation waiting");
               fail_count++;
            end else begin
               want = pending_gains.pop_front();
               if (rsp_if.distance !== want.distance) begin
                  $error("distance: expected %0d, actual %0d", want.distance, rsp_if.distance);
                  fail_count++;
               end
               if (rsp_if.gain_left !== want.left) begin
                  $error("gain_left: expected %0d, actual %0d", want.left, rsp_if.gain_left);
                  fail_count++;
               end
               if (rsp_if.gain_right !== want.right) begin
                  $error("gain_right: expected %0d, actual %0d", want.right,
                         rsp_if.gain_right);
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            s.sx = req_if.source_x; s.sy = req_if.source_y; s.sz = req_if.source_z;
            s.gain = req_if.source_gain;
            s.lx = req_if.listener_x; s.ly = req_if.listener_y; s.lz = req_if.listener_z;
            s.rx = req_if.right_x; s.ry = req_if.right_y; s.rz = req_if.right_z;
            pending_gains.push_back(predict_gains(s));
         end
      end
   end

   // Result side: random stall bursts, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_source(source_rec_type s);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.source_x = s.sx; req_if.source_y = s.sy; req_if.source_z = s.sz;
      req_if.source_gain = s.gain;
      req_if.listener_x = s.lx; req_if.listener_y = s.ly; req_if.listener_z = s.lz;
      req_if.right_x = s.rx; req_if.right_y = s.ry; req_if.right_z = s.rz;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Lowers valid and waits until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_gains.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(ssg_pkg::csr_index_type idx, logic [19:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_penable = 1'b0; csr_pwrite = 1'b1;
      csr_paddr = ssg_pkg::CSR_ADDR_W'(idx * 4);
      csr_pwdata = ssg_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      if (idx == ssg_pkg::CSR_REF_DISTANCE) rolloff_sq_ref = value;
      else cutoff_dist = value;
   endtask

   function automatic source_rec_type make_source(logic [19:0] sx, logic [19:0] sy,
      logic [19:0] sz, logic [15:0] g, logic [19:0] lx, logic [19:0] ly, logic [19:0] lz,
      logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
      source_rec_type s;
      s.sx = sx; s.sy = sy; s.sz = sz; s.gain = g;
      s.lx = lx; s.ly = ly; s.lz = lz;
      s.rx = rx; s.ry = ry; s.rz = rz;
      return s;
   endfunction

   // Mostly sources near the listener with unit right vectors; some raw noise.
   function automatic source_rec_type random_source();
      source_rec_type s;
      int span, axis;
      s.lx = 20'($urandom); s.ly = 20'($urandom); s.lz = 20'($urandom);
      s.gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20000));
      if ($urandom_range(0, 4) == 0) begin
         s.sx = 20'($urandom); s.sy = 20'($urandom); s.sz = 20'($urandom);
      end else begin
         span = 1 << $urandom_range(0, 16);
         s.sx = s.lx + 20'($urandom_range(0, 2 * span) - span);
         s.sy = s.ly + 20'($urandom_range(0, 2 * span) - span);
         s.sz = s.lz + 20'($urandom_range(0, 2 * span) - span);
      end
      if ($urandom_range(0, 3) == 0) begin
         s.rx = 16'($urandom); s.ry = 16'($urandom); s.rz = 16'($urandom);
      end else begin
         axis = $urandom_range(0, 2);
         s.rx = (axis == 0) ? ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384) : 16'sd0;
         s.ry = (axis == 1) ? ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384) : 16'sd0;
         s.rz = (axis == 2) ? ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384) : 16'sd0;
      end
      return s;
   endfunction

   task automatic test_directed_cases();
      send_source(make_source(0, 0, 0, 16'h0000, 0, 0, 0, 16'h4000, 0, 0));
      send_source(make_source(100, 200, 300, 16'hFFFF, 100, 200, 300, 0, 0, 0));
      send_source(make_source(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'h8000,
                              20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_source(make_source(20'h00100, 0, 0, 16'h4000, 0, 0, 0, 16'h4000, 0, 0));
      send_source(make_source(0, 0, 0, 16'h4000, 20'h00100, 0, 0, 16'h4000, 0, 0));
      send_source(make_source(0, 20'h00100, 0, 16'h4000, 0, 0, 0, 16'hC000, 0, 0));
      send_source(make_source(0, 0, 0, 16'hFFFF, 20'h80000, 20'h80000, 20'h80000,
                              16'h8000, 16'h8000, 16'h8000));
      send_source(make_source(20'hFFFFF, 0, 0, 16'h4000, 0, 0, 0, 16'h4000, 0, 0));
      send_source(make_source(0, 20'h00001, 0, 16'hFFFF, 0, 0, 0, 0, 16'h4000, 0));
      send_source(make_source(0, 0, 20'h00001, 16'hFFFF, 0, 0, 0, 0, 0, 16'hC000));
      send_source(make_source(20'h7FFFF, 0, 0, 16'h4000, 0, 0, 0, 16'h7FFF, 0, 0));
      send_source(make_source(20'h12345, 20'hABCDE, 20'h55555, 16'hAAAA,
                              20'hEDCBA, 20'h54321, 20'hAAAAA, 16'h5555, 16'hAAAA, 16'h1234));
      send_source(make_source(20'h00080, 20'h00080, 0, 16'h7FFF, 0, 0, 0,
                              16'h2D41, 16'h2D41, 0));
      send_source(make_source(20'h00200, 0, 0, 16'h4000, 0, 0, 0, 0, 16'h4000, 0));
      drain_results();
   endtask

   task automatic test_register_extremes();
      write_register(ssg_pkg::CSR_MAX_DISTANCE, 20'd0);
      write_register(ssg_pkg::CSR_REF_DISTANCE, 20'd1);
      // A zero cutoff still lets a coincident source through, its gain capped at unity.
      send_source(make_source(5, 5, 5, 16'hFFFF, 5, 5, 5, 0, 0, 0));
      send_source(make_source(6, 5, 5, 16'hFFFF, 5, 5, 5, 16'h4000, 0, 0));
      drain_results();
      write_register(ssg_pkg::CSR_MAX_DISTANCE, 20'd256);
      send_source(make_source(256, 0, 0, 16'h4000, 0, 0, 0, 16'h4000, 0, 0));
      send_source(make_source(257, 0, 0, 16'h4000, 0, 0, 0, 16'h4000, 0, 0));
      drain_results();
      write_register(ssg_pkg::CSR_REF_DISTANCE, 20'hFFFFF);
      write_register(ssg_pkg::CSR_MAX_DISTANCE, 20'hFFFFF);
      send_source(make_source(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF, 0, 0, 0,
                              16'h4000, 16'h4000, 16'h4000));
      drain_results();
   endtask

   task automatic test_random_phase(logic [19:0] rolloff, logic [19:0] cutoff, int count);
      write_register(ssg_pkg::CSR_REF_DISTANCE, rolloff);
      write_register(ssg_pkg::CSR_MAX_DISTANCE, cutoff);
      repeat (count) send_source(random_source());
      drain_results();
   endtask

   task automatic test_output_backpressure();
      // Hold the result side long enough that the pipeline fills and stalls.
      @(negedge clock);
      hold_cycles = 300;
      repeat (150) send_source(random_source());
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_phase(20'd256, 20'hFFFFF, 300);
      test_random_phase(20'd1, 20'h20000, 250);
      test_random_phase(20'hFFFFF, 20'd0, 150);
      test_output_backpressure();
      test_random_phase(20'($urandom_range(1, 1048575)), 20'($urandom), 300);
      test_random_phase(20'd4096, 20'h40000, 250);
      idle_on = 1'b0;
      test_random_phase(20'd256, 20'hFFFFF, 200);
      if (pending_gains.size() != 0) begin
         $error("%0d expected results never arrived", pending_gains.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
